@@ hdl/gmd_pkg.sv @@
// Shared types, cell codes and register constants for the maze solver.
`timescale 1ns / 1ps

package gmd_pkg;

   // Storage size default and register reset values
   localparam int unsigned MAX_CELLS_DEFAULT = 256;
   localparam logic [7:0]  ROW_WIDTH_RESET   = 8'd21;
   localparam logic [8:0]  CELL_COUNT_RESET  = 9'd231;

   // Configuration register indexes
   localparam logic CSR_ROW_WIDTH  = 1'b0;
   localparam logic CSR_CELL_COUNT = 1'b1;

   // Function codes
   localparam logic [1:0] FUNC_WRITE = 2'd0;
   localparam logic [1:0] FUNC_READ  = 2'd1;
   localparam logic [1:0] FUNC_SOLVE = 2'd2;

   // Cell codes
   localparam logic [2:0] CODE_OPEN    = 3'd0;
   localparam logic [2:0] CODE_WALL    = 3'd1;
   localparam logic [2:0] CODE_GOAL    = 3'd2;
   localparam logic [2:0] CODE_VISITED = 3'd3;
   localparam logic [2:0] CODE_PATH    = 3'd4;
   localparam logic [2:0] CODE_REACHED = 3'd5;

   // Number of neighbour directions tried per cell
   localparam logic [2:0] TRIED_ALL = 3'd4;

   // One command word handed to the engine
   typedef struct packed {
      logic [1:0] func;
      logic [7:0] cell_index;
      logic [2:0] cell_value;
      logic [7:0] start_index;
   } cmd_type;

   // One result word returned by the engine
   typedef struct packed {
      logic       found;
      logic [2:0] read_value;
   } res_type;

endpackage

@@ hdl/gmd_engine.sv @@
// Command sequencer with the grid memory and the depth-first search stack.
`timescale 1ns / 1ps

module gmd_engine #(
   parameter int unsigned MAX_CELLS = gmd_pkg::MAX_CELLS_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic [7:0]      row_width,
   input  logic [8:0]      cell_count,
   input  logic            cmd_valid,
   output logic            cmd_ready,
   input  gmd_pkg::cmd_type cmd,
   output logic            res_valid,
   input  logic            res_ready,
   output gmd_pkg::res_type res
);
   import gmd_pkg::*;

   localparam int ADDR_W  = $clog2(MAX_CELLS);
   localparam int DEPTH_W = ADDR_W + 1;
   localparam int BW      = (DEPTH_W > 9) ? DEPTH_W : 9;
   localparam int NW      = BW + 2;
   localparam int FRAME_W = ADDR_W + 3;

   // Sequencer states
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_RD    = 4'd1;
   localparam logic [3:0] ST_START = 4'd2;
   localparam logic [3:0] ST_NEXT  = 4'd3;
   localparam logic [3:0] ST_CHECK = 4'd4;
   localparam logic [3:0] ST_POP   = 4'd5;
   localparam logic [3:0] ST_MARK  = 4'd6;
   localparam logic [3:0] ST_MARKW = 4'd7;
   localparam logic [3:0] ST_RESP  = 4'd8;

   logic [3:0]         state_ff, state_in;
   logic [ADDR_W-1:0]  top_cell_ff, top_cell_in;
   logic [2:0]         top_tried_ff, top_tried_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic [ADDR_W-1:0]  nbr_ff, nbr_in;
   logic [DEPTH_W-1:0] mark_ff, mark_in;
   logic               found_ff, found_in;
   logic [2:0]         read_ff, read_in;

   // Grid memory and search stack, both with registered read data
   logic [2:0]         grid_mem [MAX_CELLS];
   logic [2:0]         grid_rdata_ff;
   logic               grid_we, grid_re;
   logic [ADDR_W-1:0]  grid_waddr, grid_raddr;
   logic [2:0]         grid_wdata;

   logic [FRAME_W-1:0] stack_mem [MAX_CELLS];
   logic [FRAME_W-1:0] stack_rdata_ff;
   logic               stack_we, stack_re;
   logic [ADDR_W-1:0]  stack_waddr, stack_raddr;
   logic [FRAME_W-1:0] stack_wdata;

   logic [BW-1:0]      bound;
   logic               idx_ok, start_ok, nbr_ok;
   logic [ADDR_W-1:0]  cmd_addr, start_addr;
   logic signed [NW-1:0] cell_s, width_s, nbr_s;

   // Solve bound is the smaller of the cell count and the storage size
   assign bound = (BW'(cell_count) < BW'(MAX_CELLS)) ? BW'(cell_count) : BW'(MAX_CELLS);

   assign idx_ok     = ({24'd0, cmd.cell_index} < 32'(MAX_CELLS));
   assign cmd_addr   = ADDR_W'(cmd.cell_index);
   assign start_ok   = (BW'(cmd.start_index) < bound);
   assign start_addr = ADDR_W'(cmd.start_index);

   // Neighbour of the top frame in the direction it tries next
   assign cell_s  = $signed(NW'(top_cell_ff));
   assign width_s = $signed(NW'(row_width));
   always_comb begin
      case (top_tried_ff[1:0])
         2'd0:    nbr_s = cell_s + NW'(1);
         2'd1:    nbr_s = cell_s + width_s;
         2'd2:    nbr_s = cell_s - NW'(1);
         default: nbr_s = cell_s - width_s;
      endcase
   end
   assign nbr_ok = !nbr_s[NW-1] && ($unsigned(nbr_s) < NW'(bound));

   // Next-state and memory control
   always_comb begin
      state_in     = state_ff;
      top_cell_in  = top_cell_ff;
      top_tried_in = top_tried_ff;
      depth_in     = depth_ff;
      nbr_in       = nbr_ff;
      mark_in      = mark_ff;
      found_in     = found_ff;
      read_in      = read_ff;
      grid_we      = 1'b0;
      grid_waddr   = top_cell_ff;
      grid_wdata   = CODE_PATH;
      grid_re      = 1'b0;
      grid_raddr   = nbr_ff;
      stack_we     = 1'b0;
      stack_waddr  = ADDR_W'(depth_ff - DEPTH_W'(1));
      stack_wdata  = {top_tried_ff, top_cell_ff};
      stack_re     = 1'b0;
      stack_raddr  = '0;

      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               found_in = 1'b0;
               read_in  = CODE_OPEN;
               state_in = ST_RESP;
               case (cmd.func)
                  FUNC_WRITE: begin
                     if (idx_ok) begin
                        grid_we    = 1'b1;
                        grid_waddr = cmd_addr;
                        grid_wdata = cmd.cell_value;
                     end
                  end
                  FUNC_READ: begin
                     if (idx_ok) begin
                        grid_re    = 1'b1;
                        grid_raddr = cmd_addr;
                        state_in   = ST_RD;
                     end
                  end
                  FUNC_SOLVE: begin
                     if (start_ok) begin
                        grid_re     = 1'b1;
                        grid_raddr  = start_addr;
                        top_cell_in = start_addr;
                        state_in    = ST_START;
                     end
                  end
                  default: state_in = ST_RESP;
               endcase
            end
         end
         ST_RD: begin
            read_in  = grid_rdata_ff;
            state_in = ST_RESP;
         end
         ST_START: begin
            // A goal start is reached at once; an open start opens the search
            if (grid_rdata_ff == CODE_GOAL) begin
               grid_we    = 1'b1;
               grid_wdata = CODE_REACHED;
               found_in   = 1'b1;
               state_in   = ST_RESP;
            end else if (grid_rdata_ff == CODE_OPEN) begin
               grid_we      = 1'b1;
               grid_wdata   = CODE_VISITED;
               top_tried_in = 3'd0;
               depth_in     = DEPTH_W'(1);
               state_in     = ST_NEXT;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_NEXT: begin
            if (top_tried_ff >= TRIED_ALL) begin
               // All directions tried: drop the frame
               if (depth_ff == DEPTH_W'(1)) begin
                  depth_in = '0;
                  state_in = ST_RESP;
               end else begin
                  depth_in    = depth_ff - DEPTH_W'(1);
                  stack_re    = 1'b1;
                  stack_raddr = ADDR_W'(depth_ff - DEPTH_W'(2));
                  state_in    = ST_POP;
               end
            end else begin
               top_tried_in = top_tried_ff + 3'd1;
               if (nbr_ok) begin
                  nbr_in     = ADDR_W'($unsigned(nbr_s));
                  grid_re    = 1'b1;
                  grid_raddr = ADDR_W'($unsigned(nbr_s));
                  state_in   = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (grid_rdata_ff == CODE_GOAL) begin
               grid_we    = 1'b1;
               grid_waddr = nbr_ff;
               grid_wdata = CODE_REACHED;
               state_in   = ST_MARK;
            end else if (grid_rdata_ff == CODE_OPEN && depth_ff < DEPTH_W'(MAX_CELLS)) begin
               // Push the current top and descend into the neighbour
               grid_we      = 1'b1;
               grid_waddr   = nbr_ff;
               grid_wdata   = CODE_VISITED;
               stack_we     = 1'b1;
               top_cell_in  = nbr_ff;
               top_tried_in = 3'd0;
               depth_in     = depth_ff + DEPTH_W'(1);
               state_in     = ST_NEXT;
            end else begin
               state_in = ST_NEXT;
            end
         end
         ST_POP: begin
            top_cell_in  = stack_rdata_ff[ADDR_W-1:0];
            top_tried_in = stack_rdata_ff[FRAME_W-1:ADDR_W];
            state_in     = ST_NEXT;
         end
         ST_MARK: begin
            // Route marking starts with the top frame, then walks the stack
            grid_we  = 1'b1;
            found_in = 1'b1;
            if (depth_ff > DEPTH_W'(1)) begin
               stack_re    = 1'b1;
               stack_raddr = '0;
               mark_in     = DEPTH_W'(1);
               state_in    = ST_MARKW;
            end else begin
               depth_in = '0;
               state_in = ST_RESP;
            end
         end
         ST_MARKW: begin
            grid_we    = 1'b1;
            grid_waddr = stack_rdata_ff[ADDR_W-1:0];
            if (mark_ff < depth_ff - DEPTH_W'(1)) begin
               stack_re    = 1'b1;
               stack_raddr = ADDR_W'(mark_ff);
               mark_in     = mark_ff + DEPTH_W'(1);
            end else begin
               depth_in = '0;
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         depth_ff <= '0;
      end else begin
         state_ff <= state_in;
         depth_ff <= depth_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      top_cell_ff  <= top_cell_in;
      top_tried_ff <= top_tried_in;
      nbr_ff       <= nbr_in;
      mark_ff      <= mark_in;
      found_ff     <= found_in;
      read_ff      <= read_in;
   end

   // Grid memory
   always_ff @(posedge clock) begin
      if (grid_we) begin
         grid_mem[grid_waddr] <= grid_wdata;
      end
      if (grid_re) begin
         grid_rdata_ff <= grid_mem[grid_raddr];
      end
   end

   // Stack memory
   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_mem[stack_waddr] <= stack_wdata;
      end
      if (stack_re) begin
         stack_rdata_ff <= stack_mem[stack_raddr];
      end
   end

   assign cmd_ready      = (state_ff == ST_IDLE);
   assign res_valid      = (state_ff == ST_RESP);
   assign res.found      = found_ff;
   assign res.read_value = read_ff;

   // The stack is empty whenever no command is in progress
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (depth_ff == '0))
      else $error("stack not empty while idle");

   // The stack never grows beyond the storage size
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DEPTH_W'(MAX_CELLS))
      else $error("stack depth beyond storage");

   // A frame is being expanded only while the stack holds it
   a_next_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_NEXT) |-> (depth_ff != '0 && top_tried_ff <= TRIED_ALL))
      else $error("expanding without a frame");

   // A popped frame is taken up as the new top in the following cycle
   a_pop_resumes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POP) |=> (state_ff == ST_NEXT))
      else $error("pop did not resume expansion");

   // The stack walk of route marking runs only with found set
   a_mark_found: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MARKW) |-> found_ff)
      else $error("marking route without found");

endmodule

@@ hdl/grid_maze_dfs_solver.sv @@
// Top level of the depth-first maze solver: stream ports, registers, result stage.
`timescale 1ns / 1ps

//  Channel | Direction | Handshake             | Payload
//  req_    | in        | req_tvalid/req_tready | tuser func, tdata cell and start fields
//  rsp_    | out       | rsp_tvalid/rsp_tready | tdata found, read_value
//  csr_    | in        | csr_valid/csr_ready   | csr_index, csr_data
//
//  A write goes from idle straight to the response state; a read passes ST_RD first.
//  A solve reads the start cell, then reads each in-bound neighbour tried in ST_CHECK
//  (out-of-bound ones are skipped), takes each backtrack through ST_POP (not for the
//  start frame) and writes the route in ST_MARK and ST_MARKW.
//  Synchronous reset clears the sequencer, the stack depth and the output valid, and loads the configuration registers.
//  A new word is taken while the previous result still waits in the output stage.
module grid_maze_dfs_solver #(
   parameter int unsigned MAX_CELLS = gmd_pkg::MAX_CELLS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // cell_index[7:0], cell_value[10:8], start_index[18:11]
   input  logic [1:0]  req_tuser,   // func[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // found[0], read_value[3:1]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [8:0]  csr_data
);
   import gmd_pkg::*;

   logic [7:0] row_width_ff, row_width_in;
   logic [8:0] cell_count_ff, cell_count_in;
   logic       rsp_valid_ff, rsp_valid_in;
   res_type    rsp_res_ff;
   cmd_type    cmd;
   res_type    res;
   logic       res_valid, res_ready;

   // Configuration registers are always writable
   assign csr_ready = 1'b1;

   always_comb begin
      row_width_in  = row_width_ff;
      cell_count_in = cell_count_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ROW_WIDTH:  row_width_in  = csr_data[7:0];
            CSR_CELL_COUNT: cell_count_in = csr_data;
            default:        row_width_in  = row_width_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff  <= ROW_WIDTH_RESET;
         cell_count_ff <= CELL_COUNT_RESET;
      end else begin
         row_width_ff  <= row_width_in;
         cell_count_ff <= cell_count_in;
      end
   end

   // Unpack the request word
   assign cmd.func        = req_tuser;
   assign cmd.cell_index  = req_tdata[7:0];
   assign cmd.cell_value  = req_tdata[10:8];
   assign cmd.start_index = req_tdata[18:11];

   gmd_engine #(
      .MAX_CELLS(MAX_CELLS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .row_width  (row_width_ff),
      .cell_count (cell_count_ff),
      .cmd_valid  (req_tvalid),
      .cmd_ready  (req_tready),
      .cmd        (cmd),
      .res_valid  (res_valid),
      .res_ready  (res_ready),
      .res        (res)
   );

   // Output stage: loads when empty or being emptied this cycle
   assign res_ready    = res_valid && (!rsp_valid_ff || rsp_tready);
   assign rsp_valid_in = res_ready || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_ready) begin
         rsp_res_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_res_ff.read_value, rsp_res_ff.found};

endmodule
